// ===== hdl/vmt_pkg.sv =====
// ----------------------------------------------------------------------------
// vmt_pkg: shared types and constants of the virtio-mmio transport registers
// Register offsets, request and forwarding codes, and the item, result,
// configuration and state records passed between the transport modules.
// ----------------------------------------------------------------------------
package vmt_pkg;

    localparam int unsigned DefNumQueues   = 8;
    localparam int unsigned DefWindowBytes = 4096;

    localparam int unsigned CfgIdxW = 3;

    // request types
    localparam logic [1:0] REQ_READ   = 2'd0;
    localparam logic [1:0] REQ_WRITE  = 2'd1;
    localparam logic [1:0] REQ_USED   = 2'd2;
    localparam logic [1:0] REQ_CFGCHG = 2'd3;

    // register offsets
    localparam logic [11:0] OFF_MAGIC        = 12'h000;
    localparam logic [11:0] OFF_VERSION      = 12'h004;
    localparam logic [11:0] OFF_DEVICE_ID    = 12'h008;
    localparam logic [11:0] OFF_VENDOR_ID    = 12'h00C;
    localparam logic [11:0] OFF_DEV_FEAT     = 12'h010;
    localparam logic [11:0] OFF_DEV_FEAT_SEL = 12'h014;
    localparam logic [11:0] OFF_DRV_FEAT     = 12'h020;
    localparam logic [11:0] OFF_DRV_FEAT_SEL = 12'h024;
    localparam logic [11:0] OFF_QUEUE_SEL    = 12'h030;
    localparam logic [11:0] OFF_QUEUE_MAX    = 12'h034;
    localparam logic [11:0] OFF_QUEUE_READY  = 12'h044;
    localparam logic [11:0] OFF_QUEUE_NOTIFY = 12'h050;
    localparam logic [11:0] OFF_IRQ_STATUS   = 12'h060;
    localparam logic [11:0] OFF_IRQ_ACK      = 12'h064;
    localparam logic [11:0] OFF_STATUS       = 12'h070;
    localparam logic [11:0] OFF_CFG_GEN      = 12'h0FC;
    localparam logic [11:0] OFF_CFG_BASE     = 12'h100;

    localparam logic [31:0] MAGIC_VALUE   = 32'h7472_6976;
    localparam logic [31:0] VERSION_VALUE = 32'd2;

    // device feature selector, folded to three cases
    localparam logic [1:0] FSEL_LO   = 2'd0;
    localparam logic [1:0] FSEL_HI   = 2'd1;
    localparam logic [1:0] FSEL_NONE = 2'd2;

    // config space forwarding codes
    localparam logic [1:0] FWD_NONE  = 2'd0;
    localparam logic [1:0] FWD_READ  = 2'd1;
    localparam logic [1:0] FWD_WRITE = 2'd2;

    // configuration register indexes
    localparam logic [CfgIdxW-1:0] CFG_DEVICE_ID   = 3'd0;
    localparam logic [CfgIdxW-1:0] CFG_VENDOR_ID   = 3'd1;
    localparam logic [CfgIdxW-1:0] CFG_DEV_FEAT    = 3'd2;
    localparam logic [CfgIdxW-1:0] CFG_QUEUE_MAX   = 3'd3;
    localparam logic [CfgIdxW-1:0] CFG_QUEUES_USED = 3'd4;

    localparam logic [15:0] QUEUE_MAX_RESET   = 16'd256;
    localparam logic [3:0]  QUEUES_USED_RESET = 4'd1;

    // interrupt status bits
    localparam logic [1:0] IRQ_USED_BUF = 2'b01;
    localparam logic [1:0] IRQ_CFG_CHG  = 2'b10;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [11:0] offset;
        logic [3:0]  access_size;
        logic [31:0] write_data;
    } t_item;

    typedef struct packed {
        logic [31:0] read_data;
        logic [1:0]  cfg_forward;
        logic [11:0] cfg_offset;
        logic [3:0]  cfg_size;
        logic [31:0] cfg_wdata;
        logic        notify_valid;
        logic [2:0]  notify_queue;
        logic        status_event;
        logic [31:0] status_value;
        logic        irq_raise;
    } t_result;

    typedef struct packed {
        logic [31:0] device_id;
        logic [31:0] vendor_id;
        logic [63:0] device_features;
        logic [15:0] queue_max_size;
        logic [3:0]  queues_in_use;
    } t_cfg;

    typedef struct packed {
        logic [31:0] device_status;
        logic [1:0]  dev_fsel;
        logic [31:0] queue_select;
        logic [1:0]  irq_status;
        logic [31:0] config_gen;
    } t_state;

endpackage

// ===== hdl/vmt_dec.sv =====
// ----------------------------------------------------------------------------
// vmt_dec: register decode of the virtio-mmio transport
// Works out one item's result and the next transport state from the
// registered item, the configuration and the present state.
// ----------------------------------------------------------------------------
module vmt_dec #(
    parameter int unsigned QUEUE_SLOTS  = vmt_pkg::DefNumQueues,
    parameter int unsigned WINDOW_BYTES = vmt_pkg::DefWindowBytes
) (
    input  vmt_pkg::t_item         i_item,
    input  vmt_pkg::t_cfg          i_cfg,
    input  vmt_pkg::t_state        i_st,
    input  logic [QUEUE_SLOTS-1:0] i_q_ready,
    output vmt_pkg::t_result       o_res,
    output vmt_pkg::t_state        o_st,
    output logic [QUEUE_SLOTS-1:0] o_q_ready
);
    import vmt_pkg::*;

    localparam int unsigned QW = (QUEUE_SLOTS > 1) ? $clog2(QUEUE_SLOTS) : 1;
    localparam logic [6:0]  NQ = 7'(QUEUE_SLOTS);
    localparam logic [16:0] WIN = 17'(WINDOW_BYTES);

    logic [6:0]    qcnt;
    logic          qok;
    logic [QW-1:0] qidx;
    logic          nok;
    logic [QW-1:0] nidx;
    logic          in_win;
    logic [31:0]   wd;

    assign wd     = i_item.write_data;
    assign qcnt   = ({3'b0, i_cfg.queues_in_use} < NQ) ? {3'b0, i_cfg.queues_in_use} : NQ;
    assign qok    = i_st.queue_select < {25'b0, qcnt};
    assign qidx   = i_st.queue_select[QW-1:0];
    assign nok    = wd < {25'b0, qcnt};
    assign nidx   = wd[QW-1:0];
    assign in_win = {5'b0, i_item.offset} < WIN;

    always_comb begin
        o_res     = '0;
        o_st      = i_st;
        o_q_ready = i_q_ready;
        case (i_item.req_type)
            REQ_USED: begin
                o_st.irq_status = i_st.irq_status | IRQ_USED_BUF;
                o_res.irq_raise = 1'b1;
            end
            REQ_CFGCHG: begin
                o_st.config_gen = i_st.config_gen + 32'd1;
                o_st.irq_status = i_st.irq_status | IRQ_CFG_CHG;
                o_res.irq_raise = 1'b1;
            end
            default: begin
                if (!in_win) begin
                    // drop accesses past the window
                end else if (i_item.offset >= OFF_CFG_BASE) begin
                    o_res.cfg_forward = (i_item.req_type == REQ_READ) ? FWD_READ : FWD_WRITE;
                    o_res.cfg_offset  = i_item.offset - OFF_CFG_BASE;
                    o_res.cfg_size    = i_item.access_size;
                    if (i_item.req_type == REQ_WRITE) begin
                        o_res.cfg_wdata = wd;
                    end
                end else if (i_item.req_type == REQ_READ) begin
                    case (i_item.offset)
                        OFF_MAGIC:     o_res.read_data = MAGIC_VALUE;
                        OFF_VERSION:   o_res.read_data = VERSION_VALUE;
                        OFF_DEVICE_ID: o_res.read_data = i_cfg.device_id;
                        OFF_VENDOR_ID: o_res.read_data = i_cfg.vendor_id;
                        OFF_DEV_FEAT: begin
                            case (i_st.dev_fsel)
                                FSEL_LO: o_res.read_data = i_cfg.device_features[31:0];
                                FSEL_HI: o_res.read_data = i_cfg.device_features[63:32];
                                default: o_res.read_data = '0;
                            endcase
                        end
                        OFF_QUEUE_MAX: begin
                            if (qok) o_res.read_data = {16'b0, i_cfg.queue_max_size};
                        end
                        OFF_QUEUE_READY: begin
                            if (qok) o_res.read_data = {31'b0, i_q_ready[qidx]};
                        end
                        OFF_IRQ_STATUS: o_res.read_data = {30'b0, i_st.irq_status};
                        OFF_STATUS:     o_res.read_data = i_st.device_status;
                        OFF_CFG_GEN:    o_res.read_data = i_st.config_gen;
                        default:        o_res.read_data = '0;
                    endcase
                end else begin
                    case (i_item.offset)
                        OFF_DEV_FEAT_SEL: begin
                            o_st.dev_fsel = (wd == 32'd0) ? FSEL_LO :
                                            (wd == 32'd1) ? FSEL_HI : FSEL_NONE;
                        end
                        OFF_QUEUE_SEL: o_st.queue_select = wd;
                        OFF_QUEUE_READY: begin
                            if (qok) o_q_ready[qidx] = (wd == 32'd1);
                        end
                        OFF_QUEUE_NOTIFY: begin
                            if (nok && i_q_ready[nidx]) begin
                                o_res.notify_valid = 1'b1;
                                o_res.notify_queue = wd[2:0];
                            end
                        end
                        OFF_IRQ_ACK: o_st.irq_status = i_st.irq_status & ~wd[1:0];
                        OFF_STATUS: begin
                            if (wd == 32'd0) begin
                                o_st.device_status = '0;
                                o_st.dev_fsel      = FSEL_LO;
                                o_st.queue_select  = '0;
                                o_st.irq_status    = '0;
                                o_q_ready          = '0;
                            end else begin
                                o_st.device_status = wd;
                            end
                            o_res.status_event = 1'b1;
                            o_res.status_value = wd;
                        end
                        default: begin
                            // hold state for unknown or read-only offsets
                        end
                    endcase
                end
            end
        endcase
    end

endmodule

// ===== hdl/virtio_mmio_transport_regs.sv =====
// ----------------------------------------------------------------------------
// virtio_mmio_transport_regs: virtio-mmio transport register file
// Decodes bus reads and writes at the standard register offsets, forwards
// config space accesses, raises interrupts on device events.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel: drive i_req_type, i_offset, i_access_size, i_write_data
//   with i_start; an item is taken at each edge with i_start high and o_busy
//   low. o_busy stays low, so one item can enter every cycle.
//   Result channel: o_done marks one cycle in which all result ports hold the
//   item's result. An item passes the input register, the decode and the
//   result register on its way to the result ports; throughput 1 item per
//   cycle. The receiver cannot stall; every result is taken in its cycle.
//   Configuration channel: i_cfg_valid / o_cfg_ready with i_cfg_index and
//   i_cfg_data; o_cfg_ready is always high. Write it only while idle.
//   Reset (i_rst_n low, synchronous) drops any item in flight, clears all
//   transport state and loads configuration defaults (queue max size 256,
//   one queue in use). A status write of zero clears the transport state
//   except the config generation count.
// ----------------------------------------------------------------------------
module virtio_mmio_transport_regs #(
    parameter int unsigned QUEUE_SLOTS  = vmt_pkg::DefNumQueues,
    parameter int unsigned WINDOW_BYTES = vmt_pkg::DefWindowBytes
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    output logic                        o_busy,
    input  logic [1:0]                  i_req_type,
    input  logic [11:0]                 i_offset,
    input  logic [3:0]                  i_access_size,
    input  logic [31:0]                 i_write_data,
    output logic                        o_done,
    output logic [31:0]                 o_read_data,
    output logic [1:0]                  o_cfg_forward,
    output logic [11:0]                 o_cfg_offset,
    output logic [3:0]                  o_cfg_size,
    output logic [31:0]                 o_cfg_wdata,
    output logic                        o_notify_valid,
    output logic [2:0]                  o_notify_queue,
    output logic                        o_status_event,
    output logic [31:0]                 o_status_value,
    output logic                        o_irq_raise,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [vmt_pkg::CfgIdxW-1:0] i_cfg_index,
    input  logic [63:0]                 i_cfg_data
);
    import vmt_pkg::*;

    // input register
    logic                   r_in_valid;
    t_item                  r_item;
    // result register
    logic                   r_done;
    t_result                r_res;
    // transport state and configuration
    t_state                 r_st;
    logic [QUEUE_SLOTS-1:0] r_q_ready;
    t_cfg                   r_cfg;

    t_result                n_res;
    t_state                 n_st;
    logic [QUEUE_SLOTS-1:0] n_q_ready;

    assign o_busy      = 1'b0;
    assign o_cfg_ready = 1'b1;

    // capture the item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= i_start && !o_busy;
        end
        if (i_start && !o_busy) begin
            r_item.req_type    <= i_req_type;
            r_item.offset      <= i_offset;
            r_item.access_size <= i_access_size;
            r_item.write_data  <= i_write_data;
        end
    end

    vmt_dec #(
        .QUEUE_SLOTS  (QUEUE_SLOTS),
        .WINDOW_BYTES (WINDOW_BYTES)
    ) u_dec (
        .i_item    (r_item),
        .i_cfg     (r_cfg),
        .i_st      (r_st),
        .i_q_ready (r_q_ready),
        .o_res     (n_res),
        .o_st      (n_st),
        .o_q_ready (n_q_ready)
    );

    // commit the decoded item: advance state, load the result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done    <= 1'b0;
            r_st      <= '0;
            r_q_ready <= '0;
        end else begin
            r_done <= r_in_valid;
            if (r_in_valid) begin
                r_st      <= n_st;
                r_q_ready <= n_q_ready;
            end
        end
        if (r_in_valid) begin
            r_res <= n_res;
        end
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.device_id       <= '0;
            r_cfg.vendor_id       <= '0;
            r_cfg.device_features <= '0;
            r_cfg.queue_max_size  <= QUEUE_MAX_RESET;
            r_cfg.queues_in_use   <= QUEUES_USED_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_DEVICE_ID:   r_cfg.device_id       <= i_cfg_data[31:0];
                CFG_VENDOR_ID:   r_cfg.vendor_id       <= i_cfg_data[31:0];
                CFG_DEV_FEAT:    r_cfg.device_features <= i_cfg_data;
                CFG_QUEUE_MAX:   r_cfg.queue_max_size  <= i_cfg_data[15:0];
                CFG_QUEUES_USED: r_cfg.queues_in_use   <= i_cfg_data[3:0];
                default: begin
                    // drop writes to unknown indexes
                end
            endcase
        end
    end

    assign o_done         = r_done;
    assign o_read_data    = r_res.read_data;
    assign o_cfg_forward  = r_res.cfg_forward;
    assign o_cfg_offset   = r_res.cfg_offset;
    assign o_cfg_size     = r_res.cfg_size;
    assign o_cfg_wdata    = r_res.cfg_wdata;
    assign o_notify_valid = r_res.notify_valid;
    assign o_notify_queue = r_res.notify_queue;
    assign o_status_event = r_res.status_event;
    assign o_status_value = r_res.status_value;
    assign o_irq_raise    = r_res.irq_raise;

endmodule

// ===== hdl/vmt_chk.sv =====
// ----------------------------------------------------------------------------
// vmt_chk: port checker of the virtio-mmio transport registers
// Watches the top level's ports for result timing and result consistency.
// ----------------------------------------------------------------------------
module vmt_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_start,
    input logic        o_busy,
    input logic        o_done,
    input logic [31:0] o_read_data,
    input logic [1:0]  o_cfg_forward,
    input logic        o_notify_valid,
    input logic        o_status_event,
    input logic        o_irq_raise
);
    import vmt_pkg::*;

    // every accepted item gives a result after the input and result registers
    a_latency : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> ##1 o_done)
        else $error("accepted item gave no result");

    // a result needs an item accepted ahead of the input and result registers
    a_no_extra : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && $past(i_rst_n, 2)) |-> $past(i_start && !o_busy, 2))
        else $error("result without accepted item");

    // a forwarded access carries no register side effects
    a_fwd_clean : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_cfg_forward != FWD_NONE)) |->
        (o_read_data == 32'd0 && !o_notify_valid && !o_status_event && !o_irq_raise))
        else $error("forwarded access with register effects");

    // an event result is only an interrupt
    a_irq_clean : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_irq_raise) |->
        (o_cfg_forward == FWD_NONE && o_read_data == 32'd0 && !o_status_event))
        else $error("interrupt result mixed with bus result");

endmodule

bind virtio_mmio_transport_regs vmt_chk u_vmt_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_start        (i_start),
    .o_busy         (o_busy),
    .o_done         (o_done),
    .o_read_data    (o_read_data),
    .o_cfg_forward  (o_cfg_forward),
    .o_notify_valid (o_notify_valid),
    .o_status_event (o_status_event),
    .o_irq_raise    (o_irq_raise)
);
